// ----- hw/rtl/lsp_pkg.sv -----
// lsp_pkg: shared widths, constants and types of the line sensor position block
// used by lsp_front, lsp_div and line_sensor_position_and_flags
// depends on nothing
package lsp_pkg;

   // field widths
   localparam int SENSOR_W   = 10;
   localparam int LEVEL_W    = SENSOR_W + 1;
   localparam int POS_W      = 12;
   localparam int WSUM_W     = 13;
   localparam int NUM_W      = 23;
   localparam int TOTAL_W    = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int DIV_STEPS  = POS_W;
   localparam int DIV_CNT_W  = 4;

   // sensor range and fixed levels
   localparam logic [SENSOR_W-1:0] SENSOR_MAX  = SENSOR_W'(1000);
   localparam logic [SENSOR_W-1:0] SEEN_LEVEL  = SENSOR_W'(200);
   localparam logic [SENSOR_W-1:0] NOISE_LEVEL = SENSOR_W'(50);
   localparam logic [NUM_W-1:0]    WEIGHT_STEP = NUM_W'(1000);
   localparam logic [POS_W-1:0]    POS_FULL    = POS_W'((5 - 1) * 1000);
   localparam logic [POS_W-1:0]    POS_HALF    = POS_W'((5 - 1) * 1000 / 2);

   // configuration register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_ON_THRESHOLD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_BAND    = CSR_IDX_W'(1);
   localparam logic [SENSOR_W-1:0]  ON_THRESHOLD_RST = SENSOR_W'(300);
   localparam logic [SENSOR_W-1:0]  DEAD_BAND_RST    = SENSOR_W'(100);

   // one prepared sample, handed from the front end to the control
   typedef struct packed {
      logic [NUM_W-1:0]   num;
      logic [TOTAL_W-1:0] total;
      logic               seen;
      logic [4:0]         lit;
      logic               clear;
   } lsp_sample_type;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } lsp_div_stat_type;

   // clamp a reading to the sensor maximum
   function automatic logic [SENSOR_W-1:0] sat_reading(input logic [SENSOR_W-1:0] v);
      sat_reading = (v > SENSOR_MAX) ? SENSOR_MAX : v;
   endfunction

endpackage

// ----- hw/rtl/line_sensor_position_and_flags.sv -----
// line_sensor_position_and_flags: top level of the line sensor block; control,
// sticky flags, configuration registers and result register
// depends on lsp_pkg, lsp_front, lsp_div
//
//   channel  direction  ports                      payload
//   req      in         req_valid / req_ready      five readings, clear_first
//   rsp      out        rsp_valid / rsp_ready      position, line_seen, flags
//   csr      in         csr_valid / csr_ready      csr_index, csr_wdata
//
// from transfer to result a sample loads the divider, runs the bit-serial divide,
// sees it finish and fills the result register; the next transfer is taken only
// once the control is back in idle after the result register has been filled.
// reset is synchronous and active high; it resets the control and csr registers.
// a stalled result waits in the result register; the next sample is taken
// meanwhile and waits at the end of its divide until the register is free.
module line_sensor_position_and_flags (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lsp_pkg::SENSOR_W-1:0]        req_sensor_left,
   input  logic [lsp_pkg::SENSOR_W-1:0]        req_sensor_left_mid,
   input  logic [lsp_pkg::SENSOR_W-1:0]        req_sensor_center,
   input  logic [lsp_pkg::SENSOR_W-1:0]        req_sensor_right_mid,
   input  logic [lsp_pkg::SENSOR_W-1:0]        req_sensor_right,
   input  logic                                req_clear_first,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lsp_pkg::POS_W-1:0]           rsp_position,
   output logic                                rsp_line_seen,
   output logic                                rsp_crossing_flag,
   output logic                                rsp_dead_end_flag,
   output logic                                rsp_left_edge_flag,
   output logic                                rsp_right_edge_flag,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lsp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lsp_pkg::SENSOR_W-1:0]        csr_wdata
);
   import lsp_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } lsp_state_type;

   lsp_state_type      state_ff, state_in;
   lsp_sample_type     sample;
   lsp_div_stat_type   div_stat;
   logic [POS_W-1:0]   quot;
   logic [SENSOR_W-1:0] on_threshold_ff, dead_band_ff;
   logic [POS_W-1:0]   last_pos_ff, last_pos_in;
   logic [3:0]         flags_ff, flags_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               seen_ff;
   logic [3:0]         oflags_ff;
   logic               req_xfer, rsp_free, on_line, write_out;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign write_out = (state_ff == ST_DONE) && rsp_free;
   assign on_line   = sample.seen && (sample.total != '0);

   lsp_front u_front (
      .clock            (clock),
      .load             (req_xfer),
      .sensor_left      (req_sensor_left),
      .sensor_left_mid  (req_sensor_left_mid),
      .sensor_center    (req_sensor_center),
      .sensor_right_mid (req_sensor_right_mid),
      .sensor_right     (req_sensor_right),
      .clear_first      (req_clear_first),
      .on_threshold     (on_threshold_ff),
      .dead_band        (dead_band_ff),
      .sample           (sample)
   );

   lsp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_LOAD),
      .num   (sample.num),
      .den   (sample.total),
      .quot  (quot),
      .stat  (div_stat)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_xfer) state_in = ST_LOAD;
         ST_LOAD: state_in = ST_DIV;
         ST_DIV:  if (div_stat.done) state_in = ST_DONE;
         ST_DONE: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sticky flags: {crossing, dead end, left edge, right edge}
   always_comb begin
      flags_in = flags_ff;
      if (state_ff == ST_LOAD) begin
         flags_in = sample.clear ? 4'b0000 : flags_ff;
         if (&sample.lit)                                 flags_in[3] = 1'b1;
         if (!(sample.lit[1] || sample.lit[2] || sample.lit[3])) flags_in[2] = 1'b1;
         if (sample.lit[0])                               flags_in[1] = 1'b1;
         if (sample.lit[4])                               flags_in[0] = 1'b1;
      end
   end

   // position and last stored position
   always_comb begin
      last_pos_in = last_pos_ff;
      if (on_line) begin
         pos_in = quot;
      end else if (last_pos_ff < POS_HALF) begin
         pos_in = '0;
      end else begin
         pos_in = POS_FULL;
      end
      if (write_out && on_line) begin
         last_pos_in = quot;
      end
   end

   // result handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (write_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         flags_ff        <= '0;
         last_pos_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
         on_threshold_ff <= ON_THRESHOLD_RST;
         dead_band_ff    <= DEAD_BAND_RST;
      end else begin
         state_ff     <= state_in;
         flags_ff     <= flags_in;
         last_pos_ff  <= last_pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ON_THRESHOLD: on_threshold_ff <= csr_wdata;
               CSR_DEAD_BAND:    dead_band_ff    <= csr_wdata;
               default:          ;
            endcase
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (write_out) begin
         pos_ff    <= pos_in;
         seen_ff   <= on_line;
         oflags_ff <= flags_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_position        = pos_ff;
   assign rsp_line_seen       = seen_ff;
   assign rsp_crossing_flag   = oflags_ff[3];
   assign rsp_dead_end_flag   = oflags_ff[2];
   assign rsp_left_edge_flag  = oflags_ff[1];
   assign rsp_right_edge_flag = oflags_ff[0];

endmodule

// ----- hw/rtl/lsp_front.sv -----
// lsp_front: clamps the five readings, runs the on test and forms the
// weighted sum and total of the middle sensors, registered on each transfer
// depends on lsp_pkg
module lsp_front (
   input  logic                           clock,
   input  logic                           load,
   input  logic [lsp_pkg::SENSOR_W-1:0]   sensor_left,
   input  logic [lsp_pkg::SENSOR_W-1:0]   sensor_left_mid,
   input  logic [lsp_pkg::SENSOR_W-1:0]   sensor_center,
   input  logic [lsp_pkg::SENSOR_W-1:0]   sensor_right_mid,
   input  logic [lsp_pkg::SENSOR_W-1:0]   sensor_right,
   input  logic                           clear_first,
   input  logic [lsp_pkg::SENSOR_W-1:0]   on_threshold,
   input  logic [lsp_pkg::SENSOR_W-1:0]   dead_band,
   output lsp_pkg::lsp_sample_type        sample
);
   import lsp_pkg::*;

   logic [SENSOR_W-1:0]  s0, s1, s2, s3, s4;
   logic [SENSOR_W-1:0]  c1, c2, c3;
   logic [LEVEL_W-1:0]   level;
   logic [WSUM_W-1:0]    wsum;
   lsp_sample_type       sample_in, sample_ff;

   // clamp readings
   assign s0 = sat_reading(sensor_left);
   assign s1 = sat_reading(sensor_left_mid);
   assign s2 = sat_reading(sensor_center);
   assign s3 = sat_reading(sensor_right_mid);
   assign s4 = sat_reading(sensor_right);

   // only readings above the noise level count in the centroid
   assign c1 = (s1 > NOISE_LEVEL) ? s1 : '0;
   assign c2 = (s2 > NOISE_LEVEL) ? s2 : '0;
   assign c3 = (s3 > NOISE_LEVEL) ? s3 : '0;

   assign level = LEVEL_W'(on_threshold) + LEVEL_W'(dead_band);
   assign wsum  = WSUM_W'(c1) + (WSUM_W'(c2) << 1) + WSUM_W'(c3) + (WSUM_W'(c3) << 1);

   // next sample record
   always_comb begin
      sample_in.num   = NUM_W'(wsum) * WEIGHT_STEP;
      sample_in.total = TOTAL_W'(c1) + TOTAL_W'(c2) + TOTAL_W'(c3);
      sample_in.seen  = (s1 > SEEN_LEVEL) || (s2 > SEEN_LEVEL) || (s3 > SEEN_LEVEL);
      sample_in.lit   = {LEVEL_W'(s4) >= level, LEVEL_W'(s3) >= level,
                         LEVEL_W'(s2) >= level, LEVEL_W'(s1) >= level,
                         LEVEL_W'(s0) >= level};
      sample_in.clear = clear_first;
   end

   // capture on transfer
   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= sample_in;
      end
   end

   assign sample = sample_ff;

endmodule

// ----- hw/rtl/lsp_div.sv -----
// lsp_div: radix-2 restoring divider, one quotient bit per cycle through a
// shift register holding the low dividend bits and the quotient
// depends on lsp_pkg
module lsp_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lsp_pkg::NUM_W-1:0]     num,
   input  logic [lsp_pkg::TOTAL_W-1:0]   den,
   output logic [lsp_pkg::POS_W-1:0]     quot,
   output lsp_pkg::lsp_div_stat_type     stat
);
   import lsp_pkg::*;

   logic [TOTAL_W-1:0]   rem_ff, rem_in;
   logic [POS_W-1:0]     shq_ff, shq_in;
   logic [TOTAL_W-1:0]   den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [TOTAL_W:0]     trial;
   logic [TOTAL_W:0]     diff;
   logic                 qbit;

   // one trial subtraction per cycle
   assign trial = {rem_ff, shq_ff[POS_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign qbit  = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      shq_in  = shq_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // quotient stays below 4096, so the high dividend bits are below den
         rem_in  = TOTAL_W'(num[NUM_W-1:POS_W]);
         shq_in  = num[POS_W-1:0];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
         shq_in = {shq_ff[POS_W-2:0], qbit};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shq_ff <= shq_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign quot      = shq_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- tb/line_sensor_position_and_flags_tb.sv -----
// line_sensor_position_and_flags_tb: self-checking testbench for the line sensor
// position block; directed samples, then random samples over several register settings
// depends on lsp_pkg and line_sensor_position_and_flags
`timescale 1ns / 100ps

module line_sensor_position_and_flags_tb;

   localparam int RD_W  = lsp_pkg::SENSOR_W;
   localparam int POS_W = lsp_pkg::POS_W;
   localparam int IDX_W = lsp_pkg::CSR_IDX_W;

   // fixed levels of the position arithmetic
   localparam int READING_CEIL = 1000;
   localparam int LINE_LEVEL   = 200;
   localparam int NOISE_FLOOR  = 50;
   localparam int WEIGHT_UNIT  = 1000;
   localparam int POS_END      = 4000;
   localparam int POS_MID      = 2000;

   // register indexes that decode to nothing
   localparam logic [IDX_W-1:0] CSR_SPARE_LO = IDX_W'(2);
   localparam logic [IDX_W-1:0] CSR_SPARE_HI = IDX_W'(3);

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 212;

   typedef struct packed {
      logic [RD_W-1:0] left;
      logic [RD_W-1:0] left_mid;
      logic [RD_W-1:0] center;
      logic [RD_W-1:0] right_mid;
      logic [RD_W-1:0] right;
      logic            clear_first;
   } sample_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             line_seen;
      logic             crossing;
      logic             dead_end;
      logic             left_edge;
      logic             right_edge;
   } readout_type;

   typedef struct packed {
      sample_type  smp;
      logic        typed;
      readout_type want;
   } probe_row_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKED, RX_COMB} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [RD_W-1:0]   req_sensor_left = '0;
   logic [RD_W-1:0]   req_sensor_left_mid = '0;
   logic [RD_W-1:0]   req_sensor_center = '0;
   logic [RD_W-1:0]   req_sensor_right_mid = '0;
   logic [RD_W-1:0]   req_sensor_right = '0;
   logic              req_clear_first = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [POS_W-1:0]  rsp_position;
   logic              rsp_line_seen;
   logic              rsp_crossing_flag;
   logic              rsp_dead_end_flag;
   logic              rsp_left_edge_flag;
   logic              rsp_right_edge_flag;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [IDX_W-1:0]  csr_index = '0;
   logic [RD_W-1:0]   csr_wdata = '0;

   // typed-in expectation travelling with the payload of a directed row
   logic        drv_typed = 1'b0;
   readout_type drv_want = '0;

   // predictor copy of the registers and state
   logic [RD_W-1:0]  cfg_on_threshold = lsp_pkg::ON_THRESHOLD_RST;
   logic [RD_W-1:0]  cfg_dead_band    = lsp_pkg::DEAD_BAND_RST;
   logic [POS_W-1:0] track_last_pos   = '0;
   logic             seen_crossing    = 1'b0;
   logic             seen_dead_end    = 1'b0;
   logic             seen_left_edge   = 1'b0;
   logic             seen_right_edge  = 1'b0;

   readout_type   readouts_due [$];
   probe_row_type probe_rows [$];
   int            mismatches = 0;
   int unsigned   cycle_count = 0;
   int            burst_left = 0;
   rx_mode_type   rx_mode = RX_OPEN;

   line_sensor_position_and_flags DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sensor_left     (req_sensor_left),
      .req_sensor_left_mid (req_sensor_left_mid),
      .req_sensor_center   (req_sensor_center),
      .req_sensor_right_mid(req_sensor_right_mid),
      .req_sensor_right    (req_sensor_right),
      .req_clear_first     (req_clear_first),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_position        (rsp_position),
      .rsp_line_seen       (rsp_line_seen),
      .rsp_crossing_flag   (rsp_crossing_flag),
      .rsp_dead_end_flag   (rsp_dead_end_flag),
      .rsp_left_edge_flag  (rsp_left_edge_flag),
      .rsp_right_edge_flag (rsp_right_edge_flag),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // 20 ns clock
   initial begin
      forever #10 clock = ~clock;
   end

   // on level of the current settings, computed as an int so it never wraps
   function automatic int on_level();
      return int'(cfg_on_threshold) + int'(cfg_dead_band);
   endfunction

   // sticky flags and weighted centroid for one sample, advancing the tracked state
   function automatic readout_type track_line_sample(input sample_type smp);
      int          raw [5];
      int          rd [5];
      logic [4:0]  on_mask;
      int          wsum;
      int          tot;
      logic        seen;
      readout_type r;
      raw = '{int'(smp.left), int'(smp.left_mid), int'(smp.center),
              int'(smp.right_mid), int'(smp.right)};
      for (int i = 0; i < 5; i++) begin
         rd[i] = (raw[i] > READING_CEIL) ? READING_CEIL : raw[i];
         on_mask[i] = (rd[i] >= on_level());
      end
      // clear comes before this sample's events
      if (smp.clear_first) begin
         seen_crossing   = 1'b0;
         seen_dead_end   = 1'b0;
         seen_left_edge  = 1'b0;
         seen_right_edge = 1'b0;
      end
      if (&on_mask) seen_crossing = 1'b1;
      if (on_mask[4]) seen_right_edge = 1'b1;
      if (on_mask[0]) seen_left_edge = 1'b1;
      if (on_mask[3:1] == 3'b000) seen_dead_end = 1'b1;
      // centroid of the middle three, noise readings left out
      wsum = 0;
      tot  = 0;
      seen = 1'b0;
      for (int i = 1; i < 4; i++) begin
         if (rd[i] > LINE_LEVEL) seen = 1'b1;
         if (rd[i] > NOISE_FLOOR) begin
            wsum += rd[i] * i * WEIGHT_UNIT;
            tot  += rd[i];
         end
      end
      if (seen && tot != 0) begin
         track_last_pos = POS_W'(wsum / tot);
         r.position  = track_last_pos;
         r.line_seen = 1'b1;
      end else begin
         // line lost: snap to the side of the last position
         r.position  = (int'(track_last_pos) < POS_MID) ? '0 : POS_W'(POS_END);
         r.line_seen = 1'b0;
      end
      r.crossing   = seen_crossing;
      r.dead_end   = seen_dead_end;
      r.left_edge  = seen_left_edge;
      r.right_edge = seen_right_edge;
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // transfer monitor: register writes, sample prediction, result checking
   always @(posedge clock) begin
      readout_type got;
      readout_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == lsp_pkg::CSR_ON_THRESHOLD) cfg_on_threshold = csr_wdata;
            else if (csr_index == lsp_pkg::CSR_DEAD_BAND) cfg_dead_band = csr_wdata;
         end
         if (req_valid && req_ready) begin
            want = track_line_sample({req_sensor_left, req_sensor_left_mid,
                                      req_sensor_center, req_sensor_right_mid,
                                      req_sensor_right, req_clear_first});
            readouts_due.push_back(drv_typed ? drv_want : want);
         end
         if (rsp_valid && rsp_ready) begin
            if (readouts_due.size() == 0) begin
               $error("result transfer with no expectation pending");
               mismatches++;
            end else begin
               want = readouts_due.pop_front();
               got  = {rsp_position, rsp_line_seen, rsp_crossing_flag, rsp_dead_end_flag,
                       rsp_left_edge_flag, rsp_right_edge_flag};
               check_field("position", want.position, got.position);
               check_field("line_seen", want.line_seen, got.line_seen);
               check_field("crossing_flag", want.crossing, got.crossing);
               check_field("dead_end_flag", want.dead_end, got.dead_end);
               check_field("left_edge_flag", want.left_edge, got.left_edge);
               check_field("right_edge_flag", want.right_edge, got.right_edge);
            end
         end
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver stall pattern, mode redrawn each time the low byte of the cycle count is zero
   always @(posedge clock) begin
      if (cycle_count[7:0] == 8'd0) rx_mode <= rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_OPEN: begin
            rsp_ready <= 1'b1;
         end
         RX_COIN: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         RX_CHOKED: begin
            rsp_ready <= ($urandom_range(0, 9) == 0);
         end
         default: begin
            rsp_ready <= (cycle_count[3:0] < 4'd5);
         end
      endcase
   end

   // one sample transfer, then the burst and gap bookkeeping of the sender
   task automatic send_sample(input sample_type smp, input logic typed,
                              input readout_type want);
      int gap;
      req_valid            <= 1'b1;
      req_sensor_left      <= smp.left;
      req_sensor_left_mid  <= smp.left_mid;
      req_sensor_center    <= smp.center;
      req_sensor_right_mid <= smp.right_mid;
      req_sensor_right     <= smp.right;
      req_clear_first      <= smp.clear_first;
      drv_typed            <= typed;
      drv_want             <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // register write; the caller lowers csr_valid after its last write
   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [RD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // wait until every result is back and the block has gone quiet
   task automatic drain();
      req_valid <= 1'b0;
      // let the monitor log a transfer made at the edge just passed
      @(posedge clock);
      while (readouts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one reading, biased toward the on level and the fixed thresholds
   function automatic logic [RD_W-1:0] pick_reading();
      int v;
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = $urandom_range(READING_CEIL + 1, 1023);
         2, 3: v = on_level() + int'($urandom_range(0, 6)) - 3;
         4: v = $urandom_range(LINE_LEVEL - 2, LINE_LEVEL + 2);
         5: v = $urandom_range(NOISE_FLOOR - 2, NOISE_FLOOR + 2);
         6: v = $urandom_range(0, 1023);
         default: v = $urandom_range(0, READING_CEIL);
      endcase
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return RD_W'(v);
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      int         lo;
      lo = (on_level() > 1023) ? 1023 : on_level();
      case ($urandom_range(0, 19))
         // all five on the line, as at a crossing
         0, 1, 2: begin
            s.left      = RD_W'($urandom_range(lo, 1023));
            s.left_mid  = RD_W'($urandom_range(lo, 1023));
            s.center    = RD_W'($urandom_range(lo, 1023));
            s.right_mid = RD_W'($urandom_range(lo, 1023));
            s.right     = RD_W'($urandom_range(lo, 1023));
         end
         // middle readings near or below the seen level: line mostly lost
         3, 4, 5: begin
            s.left      = pick_reading();
            s.left_mid  = RD_W'($urandom_range(0, LINE_LEVEL + 20));
            s.center    = RD_W'($urandom_range(0, LINE_LEVEL + 20));
            s.right_mid = RD_W'($urandom_range(0, LINE_LEVEL + 20));
            s.right     = pick_reading();
         end
         default: begin
            s.left      = pick_reading();
            s.left_mid  = pick_reading();
            s.center    = pick_reading();
            s.right_mid = pick_reading();
            s.right     = pick_reading();
         end
      endcase
      s.clear_first = ($urandom_range(0, 7) == 0);
      return s;
   endfunction

   function automatic probe_row_type mk_row(input int l, input int lm, input int c,
                                            input int rm, input int r, input logic clr,
                                            input logic typed, input int pos,
                                            input logic seen, input logic cr,
                                            input logic de, input logic le, input logic re);
      probe_row_type row;
      row.smp   = {RD_W'(l), RD_W'(lm), RD_W'(c), RD_W'(rm), RD_W'(r), clr};
      row.typed = typed;
      row.want  = {POS_W'(pos), seen, cr, de, le, re};
      return row;
   endfunction

   // stimulus
   initial begin
      int unsigned phase_thr [PHASE_COUNT];
      int unsigned phase_band [PHASE_COUNT];
      sample_type  smp;

      phase_thr  = '{0, 1023, 1000, 0, 150, $urandom_range(0, 600), $urandom_range(0, 600),
                     lsp_pkg::ON_THRESHOLD_RST};
      phase_band = '{0, 1023, 0, 1000, 50, $urandom_range(0, 400), $urandom_range(0, 400),
                     lsp_pkg::DEAD_BAND_RST};

      // directed samples at reset settings (on level 400)
      //                      left  lmid  cent  rmid right clr typ  pos  ln cr de le re
      probe_rows.push_back(mk_row(0,    0,    0,    0,    0,    0, 1, 0,    0, 0, 1, 0, 0));
      probe_rows.push_back(mk_row(1000, 1000, 1000, 1000, 1000, 1, 1, 2000, 1, 1, 0, 1, 1));
      // readings above the maximum clamp to it
      probe_rows.push_back(mk_row(1023, 1023, 1023, 1023, 1023, 0, 1, 2000, 1, 1, 0, 1, 1));
      // lost with last position at the midpoint goes right
      probe_rows.push_back(mk_row(0,    0,    0,    0,    0,    0, 1, 4000, 0, 1, 1, 1, 1));
      probe_rows.push_back(mk_row(0,    0,    0,    0,    0,    1, 1, 4000, 0, 0, 1, 0, 0));
      probe_rows.push_back(mk_row(0,    1000, 0,    0,    0,    1, 1, 1000, 1, 0, 0, 0, 0));
      probe_rows.push_back(mk_row(0,    0,    0,    1000, 0,    0, 1, 3000, 1, 0, 0, 0, 0));
      probe_rows.push_back(mk_row(1000, 0,    0,    0,    0,    0, 1, 4000, 0, 0, 1, 1, 0));
      probe_rows.push_back(mk_row(0,    0,    0,    0,    1000, 1, 1, 4000, 0, 0, 1, 0, 1));
      // on test at and just under the level
      probe_rows.push_back(mk_row(0,    0,    400,  0,    0,    1, 1, 2000, 1, 0, 0, 0, 0));
      probe_rows.push_back(mk_row(0,    0,    399,  0,    0,    1, 1, 2000, 1, 0, 1, 0, 0));
      // seen level is exclusive
      probe_rows.push_back(mk_row(0,    0,    200,  0,    0,    1, 1, 4000, 0, 0, 1, 0, 0));
      probe_rows.push_back(mk_row(0,    0,    201,  0,    0,    0, 1, 2000, 1, 0, 1, 0, 0));
      // noise floor is exclusive
      probe_rows.push_back(mk_row(0,    50,   201,  51,   0,    1, 0, 0,    0, 0, 0, 0, 0));
      probe_rows.push_back(mk_row(0,    1000, 0,    60,   0,    0, 0, 0,    0, 0, 0, 0, 0));
      probe_rows.push_back(mk_row(400,  300,  700,  900,  399,  0, 0, 0,    0, 0, 0, 0, 0));
      // lost with last position below the midpoint goes left
      probe_rows.push_back(mk_row(0,    1000, 0,    0,    0,    1, 1, 1000, 1, 0, 0, 0, 0));
      probe_rows.push_back(mk_row(0,    0,    0,    0,    0,    1, 1, 0,    0, 0, 1, 0, 0));
      probe_rows.push_back(mk_row(1010, 1001, 51,   1023, 401,  0, 0, 0,    0, 0, 0, 0, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_rows[i]) send_sample(probe_rows[i].smp, probe_rows[i].typed,
                                          probe_rows[i].want);

      // random samples under each register setting
      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain();
         if ($urandom_range(0, 1)) begin
            write_reg(lsp_pkg::CSR_ON_THRESHOLD, RD_W'(phase_thr[p]));
            write_reg(lsp_pkg::CSR_DEAD_BAND, RD_W'(phase_band[p]));
         end else begin
            write_reg(lsp_pkg::CSR_DEAD_BAND, RD_W'(phase_band[p]));
            write_reg(lsp_pkg::CSR_ON_THRESHOLD, RD_W'(phase_thr[p]));
         end
         // unused index last, so an alias would show in the next samples
         write_reg((p % 2 == 0) ? CSR_SPARE_LO : CSR_SPARE_HI, RD_W'($urandom_range(0, 1023)));
         csr_valid <= 1'b0;
         repeat (PHASE_ITEMS) begin
            smp = random_sample();
            send_sample(smp, 1'b0, '0);
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
